>>> design/mic_pkg.sv
// Shared types, constants and helper functions of the multiprocessor interrupt controller.
package mic_pkg;

    // Number of CPUs present (1 to 8); storage always holds 8 CPU slots.
    localparam int NCPU  = 4;
    localparam int NSLOT = 8;

    // Command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RAISE = 2'd2;
    localparam logic [1:0] CMD_ACK   = 2'd3;

    // Register byte offsets
    localparam logic [7:0] OFF_LEVEL   = 8'h00;
    localparam logic [7:0] OFF_PENDING = 8'h04;
    localparam logic [7:0] OFF_FORCE   = 8'h08;
    localparam logic [7:0] OFF_CLEAR   = 8'h0C;
    localparam logic [7:0] OFF_POWER   = 8'h10;
    localparam logic [7:0] OFF_BCAST   = 8'h14;
    localparam logic [7:0] OFF_ERROR   = 8'h18;
    localparam logic [7:0] OFF_MASK_LO  = 8'h40;
    localparam logic [7:0] OFF_MASK_HI  = 8'h5F;
    localparam logic [7:0] OFF_CFORCE_LO = 8'h80;
    localparam logic [7:0] OFF_CFORCE_HI = 8'h9F;

    localparam logic [31:0] LINE_BITS = 32'h0000_FFFE;
    localparam logic [31:0] LOW_HALF  = 32'h0000_FFFF;
    localparam logic [3:0]  BARRIER_RESET = 4'd8;

    // Power status after reset: CPU count - 1, broadcast-capable bit, all but CPU 0 asleep
    localparam logic [31:0] POWER_RESET = (NCPU > 1) ?
        ((32'((NCPU - 1) & 15) << 28) | (32'd1 << 27) | LINE_BITS) : 32'd0;

    // Bits of present CPUs in the wake mask and in the packed levels word
    localparam logic [7:0]  CPU_PRESENT = 8'((16'd1 << NCPU) - 16'd1);
    localparam logic [31:0] LVL_PRESENT = 32'((64'd1 << (4 * NCPU)) - 64'd1);

    // One input beat: cmd in the lowest bits
    typedef struct packed {
        logic [2:0]  cpu;
        logic [3:0]  irl;
        logic [31:0] wdata;
        logic [7:0]  offset;
        logic [1:0]  cmd;
    } t_item;

    // One result beat: rdata in the lowest bits
    typedef struct packed {
        logic        bad_offset;
        logic [7:0]  active_cpus;
        logic [31:0] cpu_levels;
        logic [7:0]  wake_mask;
        logic [31:0] rdata;
    } t_result;

    // cmd travels on tuser, the remaining input fields on tdata
    localparam int IN_W   = $bits(t_item);
    localparam int CMD_W  = 2;
    localparam int IN_DW  = IN_W - CMD_W;
    localparam int IN_TW  = ((IN_DW + 7) / 8) * 8;
    localparam int OUT_W  = $bits(t_result);
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    // Highest set line among 1..15, 0 when none
    function automatic logic [3:0] top_line(input logic [15:0] w);
        logic [3:0] top;
        top = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (w[i]) begin
                top = 4'(i);
            end
        end
        return top;
    endfunction

endpackage

>>> design/mic_in_stage.sv
// Input register of the interrupt controller: holds one accepted beat until processed.
module mic_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mic_pkg::t_item  i_item,
    output logic            o_ready,
    input  logic            i_take,
    output logic            o_valid,
    output mic_pkg::t_item  o_item
);

    logic           r_vld;
    mic_pkg::t_item r_item;

    // Free when empty or when the held beat leaves this cycle
    assign o_ready = !r_vld || i_take;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> design/mic_core.sv
// Register file, next-state logic and result computation of the interrupt controller.
module mic_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [3:0]       i_cfg_data,
    input  logic             i_go,
    input  mic_pkg::t_item   i_item,
    output mic_pkg::t_result o_res
);

    logic [3:0]  r_barrier;
    logic [31:0] r_pending, n_pending;
    logic [31:0] r_gforce,  n_gforce;
    logic [31:0] r_level,   n_level;
    logic [31:0] r_clear,   n_clear;
    logic [31:0] r_bcast,   n_bcast;
    logic [31:0] r_error,   n_error;
    logic [31:0] r_power,   n_power;
    logic [31:0] r_mask  [mic_pkg::NSLOT];
    logic [31:0] n_mask  [mic_pkg::NSLOT];
    logic [31:0] r_force [mic_pkg::NSLOT];
    logic [31:0] n_force [mic_pkg::NSLOT];
    logic [7:0]  r_count, n_count;

    // Next state and result for the item in the input register
    always_comb begin
        logic [3:0]  bl;
        logic [2:0]  n;
        logic [3:0]  inc;
        logic [8:0]  sum;
        logic [31:0] v;
        logic [31:0] bit_w;
        logic [7:0]  off;
        logic [3:0]  lvl;

        n_pending = r_pending;
        n_gforce  = r_gforce;
        n_level   = r_level;
        n_clear   = r_clear;
        n_bcast   = r_bcast;
        n_error   = r_error;
        n_power   = r_power;
        n_mask    = r_mask;
        n_force   = r_force;
        inc       = 4'd0;
        bl        = r_barrier;
        v         = i_item.wdata;
        off       = i_item.offset;
        n         = off[4:2];
        bit_w     = 32'd1 << i_item.irl;
        o_res     = '0;

        case (i_item.cmd)
            mic_pkg::CMD_READ: begin
                if (off inside {[mic_pkg::OFF_MASK_LO:mic_pkg::OFF_MASK_HI]}) begin
                    o_res.rdata = r_mask[n];
                end else begin
                    case (off)
                        mic_pkg::OFF_LEVEL:   o_res.rdata = r_level;
                        mic_pkg::OFF_PENDING: o_res.rdata = r_pending;
                        mic_pkg::OFF_FORCE:   o_res.rdata = r_gforce;
                        mic_pkg::OFF_CLEAR:   o_res.rdata = r_clear;
                        mic_pkg::OFF_POWER:   o_res.rdata = r_power;
                        mic_pkg::OFF_BCAST:   o_res.rdata = r_bcast;
                        mic_pkg::OFF_ERROR:   o_res.rdata = r_error;
                        default:              o_res.rdata = 32'd0;
                    endcase
                end
            end
            mic_pkg::CMD_WRITE: begin
                if (off inside {[mic_pkg::OFF_MASK_LO:mic_pkg::OFF_MASK_HI]}) begin
                    // Count a powered-up CPU that newly unmasks the barrier line
                    if (!r_mask[n][bl] && v[bl] && !r_power[n]) begin
                        inc = 4'd1;
                    end
                    n_mask[n] = v;
                end else if (off inside
                             {[mic_pkg::OFF_CFORCE_LO:mic_pkg::OFF_CFORCE_HI]}) begin
                    n_force[n] = r_force[n] | v;
                    if (((v & r_mask[n]) != 32'd0) && (32'(n) < 32'(mic_pkg::NCPU))) begin
                        o_res.wake_mask[n] = 1'b1;
                    end
                end else begin
                    case (off)
                        mic_pkg::OFF_LEVEL:   n_level   = v;
                        mic_pkg::OFF_PENDING: n_pending = v;
                        mic_pkg::OFF_FORCE:   n_gforce  = r_gforce | v;
                        mic_pkg::OFF_CLEAR: begin
                            n_clear   = v;
                            n_pending = r_pending & ~(v & mic_pkg::LINE_BITS);
                        end
                        mic_pkg::OFF_POWER: begin
                            // Wake sleeping CPUs written with a one
                            for (int i = 0; i < mic_pkg::NCPU; i++) begin
                                if (v[i] && r_power[i]) begin
                                    n_power[i]         = 1'b0;
                                    o_res.wake_mask[i] = 1'b1;
                                    if (r_mask[i][bl]) begin
                                        inc = inc + 4'd1;
                                    end
                                end
                            end
                        end
                        mic_pkg::OFF_BCAST:   n_bcast   = v & mic_pkg::LINE_BITS;
                        mic_pkg::OFF_ERROR:   n_error   = v;
                        default:              o_res.bad_offset = 1'b1;
                    endcase
                end
            end
            mic_pkg::CMD_RAISE: begin
                if ((r_bcast & bit_w) != 32'd0) begin
                    if (mic_pkg::NCPU > 1) begin
                        for (int i = 0; i < mic_pkg::NCPU; i++) begin
                            if ((r_mask[i] & bit_w) != 32'd0) begin
                                n_force[i] = r_force[i] | bit_w;
                            end
                        end
                    end else if ((r_mask[0] & bit_w) != 32'd0) begin
                        n_force[0] = r_force[0] | bit_w;
                        n_gforce   = r_gforce | bit_w;
                    end
                end else begin
                    n_pending = r_pending | bit_w;
                end
                // Wake every present CPU with the line unmasked
                for (int i = 0; i < mic_pkg::NCPU; i++) begin
                    if ((r_mask[i] & bit_w) != 32'd0) begin
                        o_res.wake_mask[i] = 1'b1;
                    end
                end
            end
            mic_pkg::CMD_ACK: begin
                if ((r_force[i_item.cpu] & bit_w) != 32'd0) begin
                    n_force[i_item.cpu] = r_force[i_item.cpu] & ~bit_w;
                end else begin
                    n_pending = r_pending & ~bit_w;
                end
            end
            default: begin
                o_res.rdata = 32'd0;
            end
        endcase

        // Saturate the barrier count
        sum = {1'b0, r_count} + 9'(inc);
        n_count = sum[8] ? 8'hFF : sum[7:0];
        o_res.active_cpus = n_count;

        // Per-CPU level: forced lines first, then pending
        for (int c = 0; c < mic_pkg::NCPU; c++) begin
            lvl = mic_pkg::top_line(n_force[c][15:0] & n_mask[c][15:0]);
            if (lvl == 4'd0) begin
                lvl = mic_pkg::top_line(n_pending[15:0] & n_mask[c][15:0]);
            end
            o_res.cpu_levels[4*c +: 4] = lvl;
        end
    end

    // Advance state on each processed item; take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_barrier <= mic_pkg::BARRIER_RESET;
            r_pending <= '0;
            r_gforce  <= '0;
            r_level   <= '0;
            r_clear   <= '0;
            r_bcast   <= '0;
            r_error   <= '0;
            r_power   <= mic_pkg::POWER_RESET;
            r_count   <= '0;
            for (int i = 0; i < mic_pkg::NSLOT; i++) begin
                r_mask[i]  <= '0;
                r_force[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_barrier <= i_cfg_data;
            end
            if (i_go) begin
                r_pending <= n_pending;
                r_gforce  <= n_gforce;
                r_level   <= n_level;
                r_clear   <= n_clear;
                r_bcast   <= n_bcast;
                r_error   <= n_error;
                r_power   <= n_power;
                r_count   <= n_count;
                r_mask    <= n_mask;
                r_force   <= n_force;
            end
        end
    end

    // Only present CPUs are ever woken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |-> (o_res.wake_mask & ~mic_pkg::CPU_PRESENT) == 8'd0)
        else $error("wake of absent CPU");

    // Absent CPUs never show a level
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |-> (o_res.cpu_levels & ~mic_pkg::LVL_PRESENT) == 32'd0)
        else $error("level shown for absent CPU");

    // Bad offset flag only on writes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_item.cmd != mic_pkg::CMD_WRITE) |-> !o_res.bad_offset)
        else $error("bad offset outside write");

    // Read data is zero for anything but reads
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_item.cmd != mic_pkg::CMD_READ) |-> o_res.rdata == 32'd0)
        else $error("read data on non-read");

    // Barrier count never goes down
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("barrier count decreased");

endmodule

>>> design/mic_out_stage.sv
// Result register of the interrupt controller: holds a result beat until taken.
module mic_out_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  mic_pkg::t_result              i_res,
    output logic                          o_can_load,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [mic_pkg::OUT_TW-1:0]    o_tdata
);

    logic             r_vld;
    mic_pkg::t_result r_res;

    // Room when empty or when the held beat is taken this cycle
    assign o_can_load = !r_vld || i_tready;
    assign o_tvalid   = r_vld;
    assign o_tdata    = mic_pkg::OUT_TW'(r_res);

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_can_load) begin
            r_vld <= i_load;
        end
    end

    // Capture result
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> design/multiprocessor_interrupt_controller.sv
// Top level of the multiprocessor interrupt controller.
// Takes one command beat per cycle unless stalled (register read, register write, raise
// line, or per-CPU acknowledge) and returns one result beat per command, in order. An
// accepted beat is captured in the input register; its result is then loaded into the
// result register, which presents it on the output. Throughput is one item per clock
// unless stalled: the input register feeds a single pass of decode, register update and
// per-CPU priority encoding into the result register, and the register file updates in
// the same cycle, so each item sees the effects of the one before it. The input stalls
// only while both the input and the result register hold beats and the output is not
// ready. The barrier line must be written on its own channel only while the block is
// idle; the block itself does not enforce this. There is no clearing pass after reset.
module multiprocessor_interrupt_controller (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // barrier_line
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [3:0]                 i_cfg_data,
    // tdata from bit 0: offset[8], wdata[32], irl[4], cpu[3], zero fill
    // tuser from bit 0: cmd[2]
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [mic_pkg::IN_TW-1:0]  s_axis_tdata,
    input  logic [mic_pkg::CMD_W-1:0]  s_axis_tuser,
    // tdata from bit 0: rdata[32], wake_mask[8], cpu_levels[32], active_cpus[8],
    // bad_offset[1], zero fill
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [mic_pkg::OUT_TW-1:0] m_axis_tdata
);

    mic_pkg::t_item   s_item;
    mic_pkg::t_item   in_item;
    mic_pkg::t_result res;
    logic             in_vld;
    logic             can_load;
    logic             go;

    assign s_item      = {s_axis_tdata[mic_pkg::IN_DW-1:0], s_axis_tuser};
    assign o_cfg_ready = 1'b1;
    assign go          = in_vld && can_load;

    mic_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_item  (s_item),
        .o_ready (s_axis_tready),
        .i_take  (go),
        .o_valid (in_vld),
        .o_item  (in_item)
    );

    mic_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_go       (go),
        .i_item     (in_item),
        .o_res      (res)
    );

    mic_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (go),
        .i_res      (res),
        .o_can_load (can_load),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata)
    );

endmodule
